// ===== design/ctsc_pkg.sv =====
// Package: shared types, mode codes and constants of the clock time-set controller.
package ctsc_pkg;

  typedef logic [15:0] ticks_t;
  typedef logic [1:0]  mode_t;
  typedef logic [5:0]  minute_t;
  typedef logic [4:0]  hour_t;
  typedef logic [6:0]  led_t;
  typedef logic [1:0]  cfg_index_t;
  typedef logic [1:0]  event_type_t;

  typedef struct packed {
    mode_t   mode;
    minute_t minute_value;
    hour_t   hour_value;
    led_t    minute_led_level;
    led_t    hour_led_level;
  } result_t;

  localparam mode_t MODE_NORMAL = 2'd0;
  localparam mode_t MODE_MINUTE = 2'd1;
  localparam mode_t MODE_HOUR   = 2'd2;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  localparam logic BUTTON_MINUTE = 1'b0;
  localparam logic BUTTON_HOUR   = 1'b1;

  localparam event_type_t EVT_SHORT_RELEASE = 2'd0;
  localparam event_type_t EVT_LONG_PRESS    = 2'd1;

  localparam cfg_index_t CFG_LONG_PRESS = 2'd0;
  localparam cfg_index_t CFG_TIMEOUT    = 2'd1;
  localparam cfg_index_t CFG_BLINK      = 2'd2;

  localparam ticks_t LONG_PRESS_RESET = 16'd5000;
  localparam ticks_t TIMEOUT_RESET    = 16'd10000;
  localparam ticks_t BLINK_RESET      = 16'd333;
  localparam ticks_t TIMER_MAX        = 16'hFFFF;

  localparam led_t LED_ON  = 7'd100;
  localparam led_t LED_OFF = 7'd0;

  localparam minute_t MINUTE_LAST = 6'd59;
  localparam hour_t   HOUR_LAST   = 5'd23;

  // Saturating increment of a 16-bit timer.
  function automatic ticks_t sat_inc(input ticks_t v);
    sat_inc = (v == TIMER_MAX) ? TIMER_MAX : v + 16'd1;
  endfunction

endpackage

// ===== design/ctsc_in_if.sv =====
// Interface: input channel carrying ticks and button events.
interface ctsc_in_if
  import ctsc_pkg::*;
();
  logic        valid;
  logic        ready;
  logic        kind;
  logic        minute_button_down;
  logic        event_button;
  event_type_t event_type;

  modport source (output valid, kind, minute_button_down, event_button, event_type,
                  input ready);
  modport sink   (input valid, kind, minute_button_down, event_button, event_type,
                  output ready);
endinterface

// ===== design/ctsc_out_if.sv =====
// Interface: output channel carrying mode, time and indicator levels.
interface ctsc_out_if
  import ctsc_pkg::*;
();
  logic    valid;
  logic    ready;
  mode_t   mode;
  minute_t minute_value;
  hour_t   hour_value;
  led_t    minute_led_level;
  led_t    hour_led_level;

  modport source (output valid, mode, minute_value, hour_value, minute_led_level,
                  hour_led_level, input ready);
  modport sink   (input valid, mode, minute_value, hour_value, minute_led_level,
                  hour_led_level, output ready);
endinterface

// ===== design/clock_time_set_controller_top.sv =====
// Top level: time-set controller for a clock, state update and output buffering.
// A result is registered into the main output register or the skid entry.
// Throughput: one item per cycle while the skid entry is empty; the state
// update is a single pass of logic between the state registers, so an item can
// follow in the next cycle. The buffer takes one more item while a result waits.
// Reset (rst, synchronous): clears mode, counters, timers, LEDs and buffer,
// and loads the register defaults 5000 / 10000 / 333 ticks.
module clock_time_set_controller_top
  import ctsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  cfg_index_t cfg_index,
  input  ticks_t     cfg_data,
  ctsc_in_if.sink    item,
  ctsc_out_if.source result
);

  // Configuration registers
  ticks_t long_press_ticks;
  ticks_t timeout_ticks;
  ticks_t blink_ticks;

  // Controller state
  mode_t   mode_reg;
  minute_t minute_count;
  hour_t   hour_count;
  logic    press_active;
  ticks_t  press_timer;
  ticks_t  idle_timer;
  ticks_t  blink_timer;
  logic    blink_phase;
  led_t    minute_led;
  led_t    hour_led;

  mode_t   mode_next;
  minute_t minute_count_next;
  hour_t   hour_count_next;
  logic    press_active_next;
  ticks_t  press_timer_next;
  ticks_t  idle_timer_next;
  ticks_t  blink_timer_next;
  logic    blink_phase_next;
  led_t    minute_led_next;
  led_t    hour_led_next;
  logic    long_hit;

  // Output buffer: main register plus one skid entry
  result_t out_data;
  logic    out_valid;
  result_t skid_data;
  logic    skid_valid;
  result_t new_result;

  logic in_xfer;
  logic out_xfer;

  assign item.ready = !skid_valid;
  assign in_xfer    = item.valid && item.ready;
  assign out_xfer   = out_valid && result.ready;

  // Configuration writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LONG_PRESS_RESET;
      timeout_ticks    <= TIMEOUT_RESET;
      blink_ticks      <= BLINK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LONG_PRESS: long_press_ticks <= cfg_data;
        CFG_TIMEOUT:    timeout_ticks    <= cfg_data;
        CFG_BLINK:      blink_ticks      <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Next-state logic for one item.
  always_comb begin
    mode_next         = mode_reg;
    minute_count_next = minute_count;
    hour_count_next   = hour_count;
    press_active_next = press_active;
    press_timer_next  = press_timer;
    idle_timer_next   = idle_timer;
    blink_timer_next  = blink_timer;
    blink_phase_next  = blink_phase;
    minute_led_next   = minute_led;
    hour_led_next     = hour_led;
    long_hit          = 1'b0;

    if (item.kind == KIND_TICK) begin
      if (item.minute_button_down) begin
        // New press: light the minute LED and restart the hold count.
        if (!press_active) begin
          press_active_next = 1'b1;
          press_timer_next  = '0;
          minute_led_next   = LED_ON;
        end
        press_timer_next = sat_inc(press_timer_next);
        if (press_timer_next >= long_press_ticks) begin
          // Held long enough: enter minute mode and end this tick.
          long_hit          = 1'b1;
          mode_next         = MODE_MINUTE;
          idle_timer_next   = '0;
          blink_timer_next  = '0;
          blink_phase_next  = 1'b0;
          minute_led_next   = LED_OFF;
          press_active_next = 1'b0;
        end
      end else if (press_active) begin
        press_active_next = 1'b0;
        minute_led_next   = LED_OFF;
      end

      if (!long_hit && mode_reg != MODE_NORMAL) begin
        idle_timer_next = sat_inc(idle_timer);
        if (idle_timer_next >= timeout_ticks) begin
          // Inactivity timeout: drop only the LED of the mode being left.
          if (mode_reg == MODE_MINUTE) begin
            minute_led_next = LED_OFF;
          end
          if (mode_reg == MODE_HOUR) begin
            hour_led_next = LED_OFF;
          end
          mode_next        = MODE_NORMAL;
          idle_timer_next  = '0;
          blink_timer_next = '0;
          blink_phase_next = 1'b0;
        end else begin
          blink_timer_next = sat_inc(blink_timer);
          if (blink_timer_next >= blink_ticks) begin
            blink_timer_next = '0;
            blink_phase_next = !blink_phase;
            if (mode_reg == MODE_MINUTE) begin
              minute_led_next = blink_phase_next ? LED_ON : LED_OFF;
            end
            if (mode_reg == MODE_HOUR) begin
              hour_led_next = blink_phase_next ? LED_ON : LED_OFF;
            end
          end
        end
      end
    end else begin
      // Any event inside a setting mode restarts the inactivity count.
      if (mode_reg != MODE_NORMAL) begin
        idle_timer_next = '0;
      end
      if (item.event_type == EVT_LONG_PRESS) begin
        idle_timer_next  = '0;
        blink_timer_next = '0;
        blink_phase_next = 1'b0;
        if (item.event_button == BUTTON_MINUTE) begin
          mode_next       = MODE_MINUTE;
          minute_led_next = LED_OFF;
        end else begin
          mode_next     = MODE_HOUR;
          hour_led_next = LED_OFF;
        end
      end else if (item.event_type == EVT_SHORT_RELEASE) begin
        // Step the active field; a release of the other button is ignored.
        if (mode_reg == MODE_MINUTE && item.event_button == BUTTON_MINUTE) begin
          minute_count_next = (minute_count >= MINUTE_LAST) ? '0 : minute_count + 6'd1;
        end else if (mode_reg == MODE_HOUR && item.event_button == BUTTON_HOUR) begin
          hour_count_next = (hour_count >= HOUR_LAST) ? '0 : hour_count + 5'd1;
        end
      end
    end

    new_result.mode             = mode_next;
    new_result.minute_value     = minute_count_next;
    new_result.hour_value       = hour_count_next;
    new_result.minute_led_level = minute_led_next;
    new_result.hour_led_level   = hour_led_next;
  end

  // Advance the state on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= MODE_NORMAL;
      minute_count <= '0;
      hour_count   <= '0;
      press_active <= 1'b0;
      press_timer  <= '0;
      idle_timer   <= '0;
      blink_timer  <= '0;
      blink_phase  <= 1'b0;
      minute_led   <= LED_OFF;
      hour_led     <= LED_OFF;
    end else if (in_xfer) begin
      mode_reg     <= mode_next;
      minute_count <= minute_count_next;
      hour_count   <= hour_count_next;
      press_active <= press_active_next;
      press_timer  <= press_timer_next;
      idle_timer   <= idle_timer_next;
      blink_timer  <= blink_timer_next;
      blink_phase  <= blink_phase_next;
      minute_led   <= minute_led_next;
      hour_led     <= hour_led_next;
    end
  end

  // Output buffer control. A new result goes to the main register when it is
  // free or draining this cycle, otherwise it is parked in the skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        if (!out_valid || out_xfer) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_xfer) begin
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (!out_valid || out_xfer) begin
        out_data <= new_result;
      end else begin
        skid_data <= new_result;
      end
    end else if (out_xfer && skid_valid) begin
      out_data <= skid_data;
    end
  end

  assign result.valid            = out_valid;
  assign result.mode             = out_data.mode;
  assign result.minute_value     = out_data.minute_value;
  assign result.hour_value       = out_data.hour_value;
  assign result.minute_led_level = out_data.minute_led_level;
  assign result.hour_led_level   = out_data.hour_led_level;

endmodule

// ===== design/ctsc_checker.sv =====
// Checker: port-level properties of the clock time-set controller, and its bind.
module ctsc_checker
  import ctsc_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_ready,
  input mode_t   mode,
  input minute_t minute_value,
  input hour_t   hour_value,
  input led_t    minute_led_level,
  input led_t    hour_led_level
);

  // A stalled result keeps its valid.
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its mode, minute and hour fields.
  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(minute_value) && $stable(hour_value) &&
                                $stable(mode))
    else $error("result payload changed while stalled");

  // Nothing is shown right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Time fields and the mode stay in range.
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> minute_value <= MINUTE_LAST && hour_value <= HOUR_LAST &&
                  mode <= MODE_HOUR)
    else $error("time or mode out of range");

  // Indicator levels are either off or fully on.
  a_led_levels: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (minute_led_level == LED_OFF || minute_led_level == LED_ON) &&
                  (hour_led_level == LED_OFF || hour_led_level == LED_ON))
    else $error("indicator level neither off nor on");

endmodule

bind clock_time_set_controller_top ctsc_checker u_ctsc_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (result.valid),
  .out_ready        (result.ready),
  .mode             (result.mode),
  .minute_value     (result.minute_value),
  .hour_value       (result.hour_value),
  .minute_led_level (result.minute_led_level),
  .hour_led_level   (result.hour_led_level)
);
